// ----- hdl/append_request_deserializer_macros.svh -----
// assertion macros for the append request deserializer
// no dependencies; included by modules that carry assertions
`ifndef APPEND_REQUEST_DESERIALIZER_MACROS_SVH
`define APPEND_REQUEST_DESERIALIZER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ARD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ARD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ard_pkg.sv -----
// types and constants for the append request deserializer
// no dependencies; imported by ard_parser and append_request_deserializer
package ard_pkg;

   typedef enum logic [3:0] {
      KIND_TERM         = 4'd0,
      KIND_LEADER       = 4'd1,
      KIND_PREV_INDEX   = 4'd2,
      KIND_PREV_TERM    = 4'd3,
      KIND_COMMIT       = 4'd4,
      KIND_COUNT        = 4'd5,
      KIND_ENTRY_INDEX  = 4'd6,
      KIND_ENTRY_TERM   = 4'd7,
      KIND_ENTRY_VALUE  = 4'd8,
      KIND_NONE         = 4'd9
   } field_kind_type;

   localparam logic [2:0] LAST_BYTE_SHORT = 3'd3;
   localparam logic [2:0] LAST_BYTE_LONG  = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      field_kind_type field_kind;
      logic [63:0]    field_value;
      logic [31:0]    entry_number;
      logic           message_end;
      logic           status;
   } rsp_type;

endpackage

// ----- hdl/ard_parser.sv -----
// field parser: message state, byte accumulator and result formation
// depends on ard_pkg and append_request_deserializer_macros.svh
`include "append_request_deserializer_macros.svh"

module ard_parser
   import ard_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type step_req,
   output logic    emit,
   output rsp_type result
);

   field_kind_type pos_ff, pos_in;
   logic [2:0]     bif_ff, bif_in;
   logic [63:0]    acc_ff, acc_in;
   logic [31:0]    rem_ff, rem_in;
   logic [31:0]    cnt_ff, cnt_in;
   logic           done_ff, done_in;

   logic [63:0] acc_shift;
   logic [2:0]  bif_last;
   logic        complete;
   logic [31:0] rem_dec;
   logic        is_count;
   logic        is_value;
   logic        last;

   assign last      = step_req.last_byte;
   assign acc_shift = {acc_ff[55:0], step_req.data_byte};
   assign bif_last  = (pos_ff == KIND_LEADER || pos_ff == KIND_COUNT) ?
                      LAST_BYTE_SHORT : LAST_BYTE_LONG;
   assign complete  = !done_ff && (bif_ff == bif_last);
   assign rem_dec   = rem_ff - 32'd1;
   assign is_count  = (pos_ff == KIND_COUNT);
   assign is_value  = (pos_ff >= KIND_ENTRY_VALUE);

   always_comb begin
      pos_in  = pos_ff;
      bif_in  = bif_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (!done_ff) begin
         if (complete) begin
            bif_in = 3'd0;
            acc_in = 64'd0;
            if (is_count) begin
               rem_in = acc_shift[31:0];
               cnt_in = 32'd0;
               if (acc_shift[31:0] == 32'd0) begin
                  done_in = 1'b1;
               end else begin
                  pos_in = KIND_ENTRY_INDEX;
               end
            end else if (is_value) begin
               cnt_in = cnt_ff + 32'd1;
               rem_in = rem_dec;
               if (rem_dec == 32'd0) begin
                  done_in = 1'b1;
               end else begin
                  pos_in = KIND_ENTRY_INDEX;
               end
            end else begin
               pos_in = field_kind_type'(pos_ff + 4'd1);
            end
         end else begin
            bif_in = bif_ff + 3'd1;
            acc_in = acc_shift;
         end
      end
   end

   always_comb begin
      emit                = complete || last;
      result.field_kind   = complete ? pos_ff : KIND_NONE;
      result.field_value  = complete ? acc_shift : 64'd0;
      result.entry_number = (complete && pos_ff >= KIND_ENTRY_INDEX) ? cnt_ff : 32'd0;
      result.message_end  = last;
      result.status       = last && !done_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         pos_ff  <= KIND_TERM;
         bif_ff  <= 3'd0;
         acc_ff  <= 64'd0;
         rem_ff  <= 32'd0;
         cnt_ff  <= 32'd0;
         done_ff <= 1'b0;
      end else if (step) begin
         pos_ff  <= pos_in;
         bif_ff  <= bif_in;
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   `ARD_ASSERT_IMPLY(a_pos_range, clock, reset, 1'b1, pos_ff <= KIND_ENTRY_VALUE, "field position out of range")
   `ARD_ASSERT_IMPLY(a_status_end, clock, reset, step && result.status, result.message_end, "truncated status without message end")
   `ARD_ASSERT_IMPLY(a_short_field, clock, reset, pos_ff == KIND_LEADER || pos_ff == KIND_COUNT, bif_ff <= LAST_BYTE_SHORT, "four byte field overran")
   `ARD_ASSERT_NEXT(a_end_clears, clock, reset, step && last, pos_ff == KIND_TERM && bif_ff == 3'd0 && !done_ff, "state not cleared after message end")
   `ARD_ASSERT_IMPLY(a_done_idle, clock, reset, done_ff, bif_ff == 3'd0 && acc_ff == 64'd0, "accumulator busy after complete message")

endmodule

// ----- hdl/append_request_deserializer.sv -----
// append request deserializer: one byte per request; a result per completed field or last byte
// path: an accepted request is held in the input register, then its result in the result register
// throughput: one request every cycle when not stalled; the single-pass parse sets it
// a result held under stall lets one more request into the input register, then stalls input
// reset: synchronous, active high; clears both valid flags and returns the parser to term
// depends on ard_pkg and ard_parser
module append_request_deserializer
   import ard_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic    out_free;
   logic    req_accept;
   logic    step;
   logic    emit;
   rsp_type result;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step && emit;
      end
   end

   ard_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .step_req (in_req_ff),
      .emit     (emit),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff <= req_payload;
      end
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
